### sv/lis_pkg.sv
// shared types and constants for the loop interval statistics block
package lis_pkg;
	localparam int IntervalBits = 24;
	localparam int CountBits = 20;
	localparam int MeanBits = IntervalBits + 8;
	localparam int VarBits = 64;
	localparam int CfgDataBits = 24;
	localparam int CfgIdxBits = 1;

	localparam logic [CfgIdxBits-1:0] RegRunLength = 1'd0;
	localparam logic [CfgIdxBits-1:0] RegNominalPeriod = 1'd1;

	localparam logic CmdStart = 1'b0;
	localparam logic CmdSample = 1'b1;

	typedef struct packed {
		logic command;
		logic [IntervalBits-1:0] interval_us;
	} lis_in_t;

	typedef struct packed {
		logic [31:0] mean_q8;
		logic [31:0] std_q8;
		logic [23:0] max_interval;
		logic [19:0] max_position;
		logic [23:0] min_interval;
		logic [19:0] min_position;
	} lis_out_t;

	// request to the shared divide / root unit
	typedef struct packed {
		logic start;
		logic is_sqrt;
		logic [VarBits-1:0] num;
		logic [CountBits:0] den;
	} lis_op_req_t;

	typedef struct packed {
		logic done;
		logic [VarBits-1:0] result;
	} lis_op_rsp_t;
endpackage

### sv/lis_if.sv
// valid/ready channel carrying one payload word
interface lis_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### sv/lis_divsqrt.sv
// shared bit-serial unsigned divider and integer square root
module lis_divsqrt (
	input logic clk,
	input logic arst_n,
	input lis_pkg::lis_op_req_t req,
	output lis_pkg::lis_op_rsp_t rsp
);
	import lis_pkg::*;

	localparam int StepBits = 7;

	logic busy_q;
	logic done_q;
	logic is_sqrt_q;
	logic [StepBits-1:0] step_q;
	logic [VarBits-1:0] num_q;
	logic [VarBits:0] rem_q;
	logic [VarBits-1:0] quo_q;
	logic [CountBits:0] den_q;
	logic [VarBits-1:0] root_q;
	logic [VarBits-1:0] bit_q;

	logic [VarBits:0] rem_sh;
	logic [VarBits:0] den_ext;
	logic [VarBits-1:0] trial;

	assign rem_sh = {rem_q[VarBits-1:0], num_q[VarBits-1]};
	assign den_ext = {{(VarBits-CountBits){1'b0}}, den_q};
	assign trial = root_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			is_sqrt_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				is_sqrt_q <= req.is_sqrt;
				step_q <= '0;
				num_q <= req.num;
				den_q <= req.den;
				rem_q <= '0;
				quo_q <= '0;
				root_q <= '0;
				bit_q <= {2'b01, {(VarBits-2){1'b0}}};
			end else if (busy_q) begin
				if (is_sqrt_q) begin
					// one result bit per cycle
					if (num_q >= trial) begin
						num_q <= num_q - trial;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (step_q == StepBits'(VarBits/2 - 1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end else begin
					num_q <= num_q << 1;
					if (rem_sh >= den_ext) begin
						rem_q <= rem_sh - den_ext;
						quo_q <= {quo_q[VarBits-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[VarBits-2:0], 1'b0};
					end
					if (step_q == StepBits'(VarBits - 1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	assign rsp = {done_q, is_sqrt_q ? root_q : quo_q};
endmodule

### sv/lis_seq.sv
// sequencer: per-sample update of mean, variance, extremes using the shared unit
module lis_seq (
	input logic clk,
	input logic arst_n,
	input logic [lis_pkg::CountBits-1:0] run_length,
	input logic [lis_pkg::IntervalBits-1:0] nominal_period,
	lis_if.sink in_ch,
	lis_if.source out_ch,
	output lis_pkg::lis_op_req_t req,
	input lis_pkg::lis_op_rsp_t rsp
);
	import lis_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DIVM, ST_SQR, ST_DIVT, ST_DIVV, ST_SQRT, ST_OUT
	} state_t;

	state_t state_q;
	logic active_q;
	logic [CountBits-1:0] num_q;
	logic [MeanBits-1:0] mean_q;
	logic [VarBits-1:0] var_q;
	logic [IntervalBits-1:0] max_q, min_q;
	logic [CountBits-1:0] max_at_q, min_at_q;
	logic [MeanBits-1:0] d_q;
	logic up_q;
	logic [VarBits-1:0] term_q;
	logic [CountBits-1:0] i_q;
	lis_out_t out_q;
	logic out_valid_q;

	logic [CountBits-1:0] i_c;
	logic [MeanBits-1:0] tq_c;
	logic [VarBits-1:0] keep_c, sum_c;
	logic [MeanBits-1:0] mean_c;
	logic [31:0] d_lo;
	logic [VarBits-1:0] sq_c;

	assign i_c = (num_q == '0) ? CountBits'(1) : num_q;
	assign tq_c = {in_ch.payload.interval_us, 8'd0};
	assign mean_c = up_q ? mean_q + MeanBits'(rsp.result) : mean_q - MeanBits'(rsp.result);
	assign d_lo = 32'(d_q);
	assign sq_c = VarBits'(d_lo) * VarBits'(d_lo);
	assign keep_c = var_q - rsp.result;
	assign sum_c = keep_c + term_q;

	assign in_ch.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			active_q <= 1'b0;
			num_q <= '0;
			mean_q <= '0;
			var_q <= '0;
			max_q <= '0;
			min_q <= '0;
			max_at_q <= '0;
			min_at_q <= '0;
			out_valid_q <= 1'b0;
			req <= '0;
		end else begin
			req.start <= 1'b0;
			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						if (in_ch.payload.command == CmdStart) begin
							mean_q <= {nominal_period, 8'd0};
							var_q <= '0;
							max_q <= nominal_period;
							min_q <= nominal_period;
							max_at_q <= '0;
							min_at_q <= '0;
							num_q <= CountBits'(1);
							active_q <= (run_length != '0);
						end else if (active_q) begin
							i_q <= i_c;
							if (in_ch.payload.interval_us > max_q) begin
								max_q <= in_ch.payload.interval_us;
								max_at_q <= i_c;
							end
							if (in_ch.payload.interval_us < min_q) begin
								min_q <= in_ch.payload.interval_us;
								min_at_q <= i_c;
							end
							up_q <= tq_c >= mean_q;
							d_q <= (tq_c >= mean_q) ? tq_c - mean_q : mean_q - tq_c;
							req.start <= 1'b1;
							req.is_sqrt <= 1'b0;
							req.num <= VarBits'((tq_c >= mean_q) ? tq_c - mean_q
								: mean_q - tq_c);
							req.den <= {1'b0, i_c} + 1'b1;
							state_q <= ST_DIVM;
						end
					end
				end
				ST_DIVM: begin
					if (rsp.done) begin
						mean_q <= mean_c;
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					req.start <= 1'b1;
					req.is_sqrt <= 1'b0;
					req.num <= sq_c;
					req.den <= {1'b0, i_q} + 1'b1;
					state_q <= ST_DIVT;
				end
				ST_DIVT: begin
					if (rsp.done) begin
						// difference beyond 32 bits saturates the term
						term_q <= (VarBits'(d_q) > VarBits'(32'hFFFF_FFFF)) ? '1
							: rsp.result;
						req.start <= 1'b1;
						req.is_sqrt <= 1'b0;
						req.num <= var_q;
						req.den <= {1'b0, i_q};
						state_q <= ST_DIVV;
					end
				end
				ST_DIVV: begin
					if (rsp.done) begin
						var_q <= (sum_c < keep_c) ? '1 : sum_c;
						if (i_q >= run_length) begin
							active_q <= 1'b0;
							num_q <= i_q;
							req.start <= 1'b1;
							req.is_sqrt <= 1'b1;
							req.num <= (sum_c < keep_c) ? '1 : sum_c;
							state_q <= ST_SQRT;
						end else begin
							num_q <= i_q + 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_SQRT: begin
					if (rsp.done) begin
						out_q.mean_q8 <= 32'(mean_q);
						out_q.std_q8 <= rsp.result[31:0];
						out_q.max_interval <= max_q;
						out_q.max_position <= max_at_q;
						out_q.min_interval <= min_q;
						out_q.min_position <= min_at_q;
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### sv/loop_interval_statistics_top.sv
// top level: config registers, sequencer and shared divide/root unit
// a sample runs three 64-step divisions through the shared bit-serial unit plus
// handoffs before the next ready, the last sample of a run also a square root;
// one word in flight at a time
// reset clears the run state and loads 1000 into run_length and nominal_period
module loop_interval_statistics_top (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [lis_pkg::CfgIdxBits-1:0] cfg_index,
	input logic [lis_pkg::CfgDataBits-1:0] cfg_data,
	lis_if.sink in_ch,
	lis_if.source out_ch
);
	import lis_pkg::*;

	logic [CountBits-1:0] run_length_q;
	logic [IntervalBits-1:0] nominal_period_q;
	lis_op_req_t req;
	lis_op_rsp_t rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_length_q <= CountBits'(1000);
			nominal_period_q <= IntervalBits'(1000);
		end else if (cfg_we) begin
			case (cfg_index)
				RegRunLength: run_length_q <= cfg_data[CountBits-1:0];
				RegNominalPeriod: nominal_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	lis_seq u_seq (
		.clk, .arst_n,
		.run_length(run_length_q),
		.nominal_period(nominal_period_q),
		.in_ch, .out_ch, .req, .rsp
	);

	lis_divsqrt u_unit (.clk, .arst_n, .req, .rsp);

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !in_ch.ready)
		else $error("input taken while unit starts");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done)
		else $error("unit done held");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid)
		else $error("result dropped");
endmodule

### verif/loop_interval_statistics_top_tb.sv
// testbench for the loop interval statistics block: directed and random runs checked against a predictor
module loop_interval_statistics_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lis_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIdxBits-1:0] cfg_index = '0;
	logic [CfgDataBits-1:0] cfg_data = '0;

	lis_if #(.T(lis_in_t)) in_ch ();
	lis_if #(.T(lis_out_t)) out_ch ();

	loop_interval_statistics_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [19:0] len_reg = 20'd1000;
	logic [23:0] period_reg = 24'd1000;
	logic armed = 1'b0;
	logic [19:0] sample_idx = '0;
	logic [31:0] avg_q8 = '0;
	logic [63:0] var_q16 = '0;
	logic [23:0] hi_val = '0, lo_val = '0;
	logic [19:0] hi_at = '0, lo_at = '0;

	lis_out_t stats_q[$];
	int errors = 0;
	int results_seen = 0;
	int words_sent = 0;
	int idle_cycles = 0;
	bit allow_idle = 1'b1;

	function automatic logic [63:0] int_root(logic [63:0] v);
		logic [63:0] r, b;
		r = '0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	task automatic predict_stats(lis_in_t w);
		logic [63:0] i, n1, tq, d, term, keep, v, tv, root;
		lis_out_t r;
		tv = 64'(w.interval_us);
		if (w.command == CmdStart) begin
			avg_q8 = {period_reg, 8'd0};
			var_q16 = '0;
			hi_val = period_reg;
			lo_val = period_reg;
			hi_at = '0;
			lo_at = '0;
			sample_idx = 20'd1;
			armed = (len_reg != 0);
		end else if (armed) begin
			i = 64'(sample_idx);
			if (i == 0) i = 1;
			n1 = i + 1;
			if (w.interval_us > hi_val) begin
				hi_val = w.interval_us;
				hi_at = i[19:0];
			end
			if (w.interval_us < lo_val) begin
				lo_val = w.interval_us;
				lo_at = i[19:0];
			end
			tq = tv << 8;
			if (tq >= 64'(avg_q8)) begin
				d = tq - 64'(avg_q8);
				avg_q8 = avg_q8 + 32'(d / n1);
			end else begin
				d = 64'(avg_q8) - tq;
				avg_q8 = avg_q8 - 32'(d / n1);
			end
			if (d > 64'hFFFF_FFFF) term = '1;
			else term = (d * d) / n1;
			keep = var_q16 - var_q16 / i;
			v = keep + term;
			if (v < keep) v = '1;
			var_q16 = v;
			if (i >= 64'(len_reg)) begin
				armed = 1'b0;
				sample_idx = i[19:0];
				root = int_root(var_q16);
				r.mean_q8 = avg_q8;
				r.std_q8 = root[31:0];
				r.max_interval = hi_val;
				r.max_position = hi_at;
				r.min_interval = lo_val;
				r.min_position = lo_at;
				stats_q.push_back(r);
			end else begin
				sample_idx = 20'(i + 1);
			end
		end
	endtask

	task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [23:0] val);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == RegRunLength) len_reg = val[19:0];
		else period_reg = val;
	endtask

	task automatic send_word(logic cmd, logic [23:0] t);
		lis_in_t w;
		int gap;
		w.command = cmd;
		w.interval_us = t;
		if (allow_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.payload <= w;
		do @(posedge clk); while (!in_ch.ready);
		predict_stats(w);
		words_sent++;
	endtask

	// wait for all results, then the block's longest latency before touching registers
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (stats_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic random_run(int n, bit wild);
		logic [23:0] t;
		send_word(CmdStart, '0);
		for (int k = 0; k < n; k++) begin
			if (wild) t = 24'($urandom);
			else t = 24'(int'(period_reg) + $signed($urandom_range(0, 64)) - 32);
			send_word(CmdSample, t);
		end
	endtask

	task automatic test_extremes();
		write_reg(RegRunLength, 24'd4);
		write_reg(RegNominalPeriod, 24'hFFFFFF);
		send_word(CmdStart, 24'hFFFFFF);
		send_word(CmdSample, 24'd0);
		send_word(CmdSample, 24'hFFFFFF);
		send_word(CmdSample, 24'hFFFFFF);
		send_word(CmdSample, 24'd0);
		drain();
		write_reg(RegNominalPeriod, 24'd0);
		send_word(CmdStart, '0);
		send_word(CmdSample, 24'd0);
		send_word(CmdSample, 24'hAAAAAA);
		send_word(CmdSample, 24'h555555);
		send_word(CmdSample, 24'd0);
		drain();
	endtask

	task automatic test_special_cases();
		// samples with no run armed are ignored
		send_word(CmdSample, 24'd77);
		write_reg(RegRunLength, 24'd1);
		write_reg(RegNominalPeriod, 24'd1000);
		send_word(CmdStart, '0);
		send_word(CmdSample, 24'd1000);
		send_word(CmdSample, 24'd5);
		drain();
		// restart mid-run
		write_reg(RegRunLength, 24'd3);
		send_word(CmdStart, '0);
		send_word(CmdSample, 24'd900);
		send_word(CmdStart, '0);
		send_word(CmdSample, 24'd1100);
		// period change mid-run only applies at next start
		drain();
		write_reg(RegNominalPeriod, 24'd500);
		send_word(CmdSample, 24'd800);
		send_word(CmdSample, 24'd1200);
		drain();
		// zero length never arms
		write_reg(RegRunLength, 24'd0);
		send_word(CmdStart, '0);
		send_word(CmdSample, 24'd10);
		drain();
		// lowering the length mid-run ends it on the next sample
		write_reg(RegRunLength, 24'd10);
		send_word(CmdStart, '0);
		send_word(CmdSample, 24'd400);
		send_word(CmdSample, 24'd600);
		send_word(CmdSample, 24'd500);
		drain();
		write_reg(RegRunLength, 24'd2);
		send_word(CmdSample, 24'd450);
		drain();
	endtask

	task automatic test_random();
		int runs;
		runs = 0;
		while (words_sent < 1150) begin
			if (runs % 8 == 0) begin
				drain();
				write_reg(RegRunLength, 24'($urandom_range(1, 24)));
				write_reg(RegNominalPeriod, 24'($urandom));
			end
			if ($urandom_range(0, 9) == 0) send_word(CmdSample, 24'($urandom));
			random_run($urandom_range(1, 26), $urandom_range(0, 3) == 0);
			runs++;
			if (runs == 30) allow_idle = 1'b0;
		end
		drain();
		// one long run at the maximum length is too slow; exercise the top value alone
		write_reg(RegRunLength, 24'hFFFFF);
		send_word(CmdStart, '0);
		for (int k = 0; k < 6; k++) send_word(CmdSample, 24'($urandom));
		send_word(CmdStart, '0);
		drain();
		allow_idle = 1'b0;
	endtask

	// result checker with random backpressure
	always @(posedge clk) begin
		lis_out_t e, g;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			g = out_ch.payload;
			results_seen++;
			if (stats_q.size() == 0) begin
				$display("%0t unexpected word %h", $time, g);
				errors++;
			end else begin
				e = stats_q.pop_front();
				if (g.mean_q8 !== e.mean_q8) begin
					$display("%0t mean_q8 exp %h got %h", $time, e.mean_q8, g.mean_q8);
					errors++;
				end
				if (g.std_q8 !== e.std_q8) begin
					$display("%0t std_q8 exp %h got %h", $time, e.std_q8, g.std_q8);
					errors++;
				end
				if (g.max_interval !== e.max_interval) begin
					$display("%0t max_interval exp %h got %h", $time, e.max_interval,
						g.max_interval);
					errors++;
				end
				if (g.max_position !== e.max_position) begin
					$display("%0t max_position exp %h got %h", $time, e.max_position,
						g.max_position);
					errors++;
				end
				if (g.min_interval !== e.min_interval) begin
					$display("%0t min_interval exp %h got %h", $time, e.min_interval,
						g.min_interval);
					errors++;
				end
				if (g.min_position !== e.min_position) begin
					$display("%0t min_position exp %h got %h", $time, e.min_position,
						g.min_position);
					errors++;
				end
			end
		end
	end

	int stall_left = 0;
	always @(posedge clk) begin
		if (allow_idle && stall_left == 0 && $urandom_range(0, 4) == 0)
			stall_left = $urandom_range(1, 7);
		if (stall_left > 0) begin
			stall_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("loop_interval_statistics_top_tb NOT OK");
			$finish;
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		out_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_extremes();
		test_special_cases();
		test_random();
		while (stats_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("sent %0d words, checked %0d statistics results", words_sent, results_seen);
		$display("covered extremes, restarts, zero and lowered run lengths, random runs");
		if (errors == 0) $display("loop_interval_statistics_top_tb OK");
		else $display("loop_interval_statistics_top_tb NOT OK");
		$finish;
	end
endmodule
